FILE: sv/lwe_pkg.sv
// Shared widths, byte codes, action codes and types of the line editor.
package lwe_pkg;

   // Field widths
   localparam int CHAR_W     = 8;
   localparam int OUT_CHAR_W = 7;
   localparam int ACT_W      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Default line length
   localparam int LINE_WIDTH_DEF = 32;

   // Byte codes with a fixed meaning
   localparam logic [CHAR_W-1:0]     CODE_EOT    = 8'h04;
   localparam logic [CHAR_W-1:0]     CODE_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0]     CODE_WERASE = 8'h17;
   localparam logic [CHAR_W-1:0]     CODE_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0]     CODE_TILDE  = 8'h7E;
   localparam logic [OUT_CHAR_W-1:0] STORE_SPACE = 7'h20;

   // Display actions
   localparam logic [ACT_W-1:0] ACT_ECHO    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_BELL    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_END     = 3'd4;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0]  CSR_ERASE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_KILL    = 1'd1;
   localparam logic [CSR_DATA_W-1:0] ERASE_RESET = 8'd127;
   localparam logic [CSR_DATA_W-1:0] KILL_RESET  = 8'd21;

   // Configuration seen by the sequencer
   typedef struct packed {
      logic [CHAR_W-1:0] erase_char;
      logic [CHAR_W-1:0] kill_char;
   } lwe_cfg_type;

endpackage

FILE: sv/lwe_if.sv
// Valid/ready channel interfaces for typed bytes and display actions.
interface lwe_req_if import lwe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface lwe_rsp_if import lwe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACT_W-1:0]      action;
   logic [OUT_CHAR_W-1:0] char_out;
   logic                  last;

   modport source (output valid, output action, output char_out, output last, input ready);
   modport sink   (input valid, input action, input char_out, input last, output ready);
endinterface

FILE: sv/line_editor_with_word_wrap.sv
// Line editor with word wrap: one typed byte per transaction in, display actions out.
// Each result passes through a pending register and an output register; kill and word erase
// first enter their own state, and a wrap holds its echo back until the scan for a space ends.
// A new byte is accepted only in the idle state, after the previous one is fully processed;
// kill emits one erase per erased column, and a wrap's scan, copy and echo share the one
// line-store read port. Reset (synchronous, active high) clears cursor, session flag and
// handshake state, and puts the configuration registers back to their reset values.
module line_editor_with_word_wrap import lwe_pkg::*; #(
   parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lwe_req_if.sink               req_if,
   lwe_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

   lwe_cfg_type           cfg_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [OUT_CHAR_W-1:0] wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [OUT_CHAR_W-1:0] rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.erase_char <= ERASE_RESET;
         cfg_ff.kill_char  <= KILL_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_ERASE: cfg_ff.erase_char <= csr_wdata;
            CSR_KILL:  cfg_ff.kill_char  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Line store
   lwe_ram #(
      .WIDTH (OUT_CHAR_W),
      .DEPTH (LINE_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Editing sequencer
   lwe_seq #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: sv/lwe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read in the cycle of a write returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lwe_seq.sv
// Sequencer: decodes each typed byte, walks the line store and emits display actions.
module lwe_seq import lwe_pkg::*; #(
   parameter int LINE_WIDTH = LINE_WIDTH_DEF,
   localparam int IDX_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1,
   localparam int CUR_W = $clog2(LINE_WIDTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lwe_cfg_type           cfg,
   lwe_req_if.sink               req_if,
   lwe_rsp_if.source             rsp_if,
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_addr,
   output logic [OUT_CHAR_W-1:0] wr_data,
   output logic [IDX_W-1:0]      rd_addr,
   input  logic [OUT_CHAR_W-1:0] rd_data
);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FLUSH  = 3'd1;
   localparam logic [2:0] S_KILL   = 3'd2;
   localparam logic [2:0] S_WERASE = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_COPY   = 3'd5;
   localparam logic [2:0] S_NL     = 3'd6;
   localparam logic [2:0] S_ECHO   = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CUR_W-1:0]      cur_ff, cur_in;
   logic                  ended_ff, ended_in;
   logic                  phase_ff, phase_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [IDX_W-1:0]      start_ff, start_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_valid_ff;
   logic [ACT_W-1:0]      pend_act_ff;
   logic [OUT_CHAR_W-1:0] pend_char_ff;
   logic                  rsp_valid_ff;
   logic [ACT_W-1:0]      rsp_act_ff;
   logic [OUT_CHAR_W-1:0] rsp_char_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   logic [ACT_W-1:0]      emit_act;
   logic [OUT_CHAR_W-1:0] emit_char;
   logic                  flush;
   logic                  out_free;
   logic                  can_emit;
   logic                  push_mid;
   logic                  push_last;
   logic                  accept;
   logic                  rd_space;
   logic [IDX_W-1:0]      cur_idx;
   logic [CHAR_W-1:0]     ch;

   // One pending result is held back so that the final one can be marked last.
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign can_emit  = !pend_valid_ff || out_free;
   assign push_mid  = emit && can_emit && pend_valid_ff;
   assign push_last = flush && out_free;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign ch           = req_if.char_in;
   assign cur_idx      = cur_ff[IDX_W-1:0];
   assign rd_space     = (rd_data == STORE_SPACE);

   // Next-state logic, memory addressing and result production
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      ended_in  = ended_ff;
      phase_in  = phase_ff;
      ptr_in    = ptr_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      emit_act  = ACT_ECHO;
      emit_char = '0;
      flush     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = cur_idx;
      wr_data   = ch[OUT_CHAR_W-1:0];
      rd_addr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && !ended_ff) begin
               if (ch == CODE_EOT && cur_ff == '0) begin
                  emit     = 1'b1;
                  emit_act = ACT_END;
                  ended_in = 1'b1;
                  state_in = S_FLUSH;
               end else if (ch == cfg.erase_char && cur_ff != '0) begin
                  emit     = 1'b1;
                  emit_act = ACT_ERASE;
                  cur_in   = cur_ff - CUR_W'(1);
                  state_in = S_FLUSH;
               end else if (ch == cfg.kill_char) begin
                  if (cur_ff != '0) begin
                     state_in = S_KILL;
                  end
               end else if (ch == CODE_WERASE) begin
                  if (cur_ff != '0) begin
                     phase_in = 1'b1;
                     rd_addr  = cur_idx - IDX_W'(1);
                     state_in = S_WERASE;
                  end
               end else if (ch == CODE_NL) begin
                  emit     = 1'b1;
                  emit_act = ACT_NEWLINE;
                  cur_in   = '0;
                  state_in = S_FLUSH;
               end else if (ch < CODE_SPACE || ch > CODE_TILDE) begin
                  emit     = 1'b1;
                  emit_act = ACT_BELL;
                  state_in = S_FLUSH;
               end else begin
                  // Printable: echo, store at the cursor and check for a full line.
                  emit      = 1'b1;
                  emit_act  = ACT_ECHO;
                  emit_char = ch[OUT_CHAR_W-1:0];
                  wr_en     = 1'b1;
                  cur_in    = cur_ff + CUR_W'(1);
                  if (cur_ff == CUR_W'(LINE_WIDTH - 1)) begin
                     if (ch == CODE_SPACE) begin
                        cnt_in   = '0;
                        state_in = S_NL;
                     end else begin
                        // The byte just stored is no space, so the scan starts below it.
                        ptr_in   = cur_idx;
                        rd_addr  = cur_idx - IDX_W'(1);
                        state_in = S_SCAN;
                     end
                  end else begin
                     state_in = S_FLUSH;
                  end
               end
            end
         end
         S_FLUSH: begin
            flush = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_KILL: begin
            if (can_emit) begin
               emit     = 1'b1;
               emit_act = ACT_ERASE;
               cur_in   = cur_ff - CUR_W'(1);
               if (cur_ff == CUR_W'(1)) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_WERASE: begin
            // Read data is the character left of the cursor.
            rd_addr = cur_idx - IDX_W'(1);
            if (phase_ff || !rd_space) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  emit_act = ACT_ERASE;
                  cur_in   = cur_ff - CUR_W'(1);
                  if (!rd_space) begin
                     phase_in = 1'b0;
                  end
                  if (cur_ff == CUR_W'(1)) begin
                     state_in = S_FLUSH;
                  end else begin
                     rd_addr = cur_idx - IDX_W'(2);
                  end
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_SCAN: begin
            // Look left of the word start for a space.
            if (ptr_ff == '0) begin
               cnt_in   = '0;
               state_in = S_NL;
            end else if (rd_space) begin
               start_in = ptr_ff;
               cnt_in   = IDX_W'(cur_ff - CUR_W'(ptr_ff));
               rd_addr  = ptr_ff;
               state_in = S_COPY;
            end else begin
               ptr_in = ptr_ff - IDX_W'(1);
               if (ptr_ff > IDX_W'(1)) begin
                  rd_addr = ptr_ff - IDX_W'(2);
               end
            end
         end
         S_COPY: begin
            // Erase one column and move one character of the word to the line start.
            rd_addr = ptr_ff;
            if (can_emit) begin
               emit     = 1'b1;
               emit_act = ACT_ERASE;
               wr_en    = 1'b1;
               wr_addr  = ptr_ff - start_ff;
               wr_data  = rd_data;
               if (CUR_W'(ptr_ff) + CUR_W'(1) == cur_ff) begin
                  state_in = S_NL;
               end else begin
                  ptr_in  = ptr_ff + IDX_W'(1);
                  rd_addr = ptr_ff + IDX_W'(1);
               end
            end
         end
         S_NL: begin
            if (can_emit) begin
               emit     = 1'b1;
               emit_act = ACT_NEWLINE;
               cur_in   = CUR_W'(cnt_ff);
               ptr_in   = '0;
               state_in = (cnt_ff == '0) ? S_FLUSH : S_ECHO;
            end
         end
         S_ECHO: begin
            // Echo the moved word from the start of the new line.
            rd_addr = ptr_ff;
            if (can_emit) begin
               emit      = 1'b1;
               emit_act  = ACT_ECHO;
               emit_char = rd_data;
               if (ptr_ff + IDX_W'(1) == cnt_ff) begin
                  state_in = S_FLUSH;
               end else begin
                  ptr_in  = ptr_ff + IDX_W'(1);
                  rd_addr = ptr_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         ended_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         ended_ff <= ended_in;
         if (emit && can_emit) begin
            pend_valid_ff <= 1'b1;
         end else if (push_last) begin
            pend_valid_ff <= 1'b0;
         end
         if (push_mid || push_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk pointers and result payload
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      ptr_ff   <= ptr_in;
      start_ff <= start_in;
      cnt_ff   <= cnt_in;
      if (emit && can_emit) begin
         pend_act_ff  <= emit_act;
         pend_char_ff <= emit_char;
      end
      if (push_mid || push_last) begin
         rsp_act_ff  <= pend_act_ff;
         rsp_char_ff <= pend_char_ff;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.action   = rsp_act_ff;
   assign rsp_if.char_out = rsp_char_ff;
   assign rsp_if.last     = rsp_last_ff;

`ifndef SYNTHESIS
   // The cursor never passes the end of the line.
   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= CUR_W'(LINE_WIDTH))
      else $error("cursor beyond line width");

   // No result is left pending once the sequencer is idle.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("pending result in idle");

   // The word copy moves characters strictly to the left.
   a_copy_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> (start_ff != '0) && (ptr_ff >= start_ff))
      else $error("word copy overlaps its source");

   // After the end of the session nothing more is produced.
   a_ended_quiet: assert property (@(posedge clock) disable iff (reset)
      ended_ff && state_ff == S_IDLE |=> state_ff == S_IDLE && !pend_valid_ff)
      else $error("activity after end of session");
`endif

endmodule
